// File: src/ttl_direct_mapped_usage_cache_macros.svh
// assertion macros for the usage cache
`ifndef TTL_DIRECT_MAPPED_USAGE_CACHE_MACROS_SVH
`define TTL_DIRECT_MAPPED_USAGE_CACHE_MACROS_SVH

// same-cycle implication
`define TTLDMC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ttldmc assertion failed");

// next-cycle implication
`define TTLDMC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ttldmc assertion failed");

`endif

// File: src/ttldmc_pkg.sv
// types, constants and codes shared by the usage cache files
`default_nettype none

package ttldmc_pkg;

   localparam int BUCKETS_DEFAULT = 256;

   localparam int OPCODE_W = 2;
   localparam int ID_W     = 22;
   localparam int TIME_W   = 48;
   localparam int KIND_W   = 2;
   localparam int COUNT_W  = 32;
   localparam int BYTES_W  = 64;
   localparam int TTL_W    = 14;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 14;
   localparam int MB_SHIFT   = 20;

   localparam logic [31:0] HASH_MULT = 32'd2654435761;

   localparam logic [TTL_W-1:0] TTL_MIN   = 14'd10;
   localparam logic [TTL_W-1:0] TTL_MAX   = 14'd10000;
   localparam logic [TTL_W-1:0] TTL_RESET = 14'd100;

   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TTL    = 2'd1;

   typedef enum logic [OPCODE_W-1:0] {
      OP_CHECK      = 2'd0,
      OP_UPDATE     = 2'd1,
      OP_INVALIDATE = 2'd2,
      OP_CLEAR      = 2'd3
   } opcode_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_QP       = 2'd0,
      KIND_MR       = 2'd1,
      KIND_MB       = 2'd2,
      KIND_SUPPLIED = 2'd3
   } kind_type;

   typedef struct packed {
      logic               valid;
      logic [ID_W-1:0]    key;
      logic [COUNT_W-1:0] qp;
      logic [COUNT_W-1:0] mr;
      logic [BYTES_W-1:0] mem;
      logic [TIME_W-1:0]  stamp;
   } line_type;

   typedef struct packed {
      opcode_type         opcode;
      logic [ID_W-1:0]    proc_id;
      logic [TIME_W-1:0]  now_ms;
      kind_type           resource_kind;
      logic [COUNT_W-1:0] supplied_count;
      logic [COUNT_W-1:0] requested;
      logic [COUNT_W-1:0] usage_limit;
      logic [COUNT_W-1:0] new_qp_count;
      logic [COUNT_W-1:0] new_mr_count;
      logic [BYTES_W-1:0] new_memory_bytes;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic               allowed;
      logic [COUNT_W-1:0] effective_count;
      logic [COUNT_W-1:0] cached_qp_count;
      logic [COUNT_W-1:0] cached_mr_count;
      logic [BYTES_W-1:0] cached_memory_bytes;
      logic [COUNT_W-1:0] hits_so_far;
      logic [COUNT_W-1:0] misses_so_far;
   } rsp_type;

endpackage

`default_nettype wire

// File: src/ttldmc_if.sv
// request, response and register write channel interfaces
`default_nettype none

interface ttldmc_req_if import ttldmc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [OPCODE_W-1:0] opcode;
   logic [ID_W-1:0]    proc_id;
   logic [TIME_W-1:0]  now_ms;
   logic [KIND_W-1:0]  resource_kind;
   logic [COUNT_W-1:0] supplied_count;
   logic [COUNT_W-1:0] requested;
   logic [COUNT_W-1:0] usage_limit;
   logic [COUNT_W-1:0] new_qp_count;
   logic [COUNT_W-1:0] new_mr_count;
   logic [BYTES_W-1:0] new_memory_bytes;

   modport source (
      output valid, opcode, proc_id, now_ms, resource_kind, supplied_count, requested,
             usage_limit, new_qp_count, new_mr_count, new_memory_bytes,
      input  ready
   );
   modport sink (
      input  valid, opcode, proc_id, now_ms, resource_kind, supplied_count, requested,
             usage_limit, new_qp_count, new_mr_count, new_memory_bytes,
      output ready
   );
endinterface

interface ttldmc_rsp_if import ttldmc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               hit;
   logic               allowed;
   logic [COUNT_W-1:0] effective_count;
   logic [COUNT_W-1:0] cached_qp_count;
   logic [COUNT_W-1:0] cached_mr_count;
   logic [BYTES_W-1:0] cached_memory_bytes;
   logic [COUNT_W-1:0] hits_so_far;
   logic [COUNT_W-1:0] misses_so_far;

   modport source (
      output valid, hit, allowed, effective_count, cached_qp_count, cached_mr_count,
             cached_memory_bytes, hits_so_far, misses_so_far,
      input  ready
   );
   modport sink (
      input  valid, hit, allowed, effective_count, cached_qp_count, cached_mr_count,
             cached_memory_bytes, hits_so_far, misses_so_far,
      output ready
   );
endinterface

interface ttldmc_csr_if import ttldmc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: src/ttldmc_hash.sv
// multiplicative hash of the process id folded to a line index
`default_nettype none

module ttldmc_hash import ttldmc_pkg::*; #(
   parameter int BUCKETS = BUCKETS_DEFAULT,
   localparam int IDX_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [ID_W-1:0]  proc_id,
   output logic             done,
   output logic [IDX_W-1:0] index
);

   localparam int  LOG_B = $clog2(BUCKETS);
   localparam bit  POW2  = ((BUCKETS & (BUCKETS - 1)) == 0);

   logic [53:0] hprod;
   logic [31:0] hash_ff;
   logic        v1_ff;

   assign hprod = 54'(proc_id) * 54'(HASH_MULT);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= start;
      end
   end

   always_ff @(posedge clock) begin
      hash_ff <= hprod[31:0];
   end

   if (POW2) begin : g_pow2
      localparam logic [31:0] MASK = 32'(BUCKETS - 1);

      assign done  = v1_ff;
      assign index = IDX_W'(hash_ff & MASK);
   end else begin : g_recip
      localparam int          SHIFT   = 32 + LOG_B;
      localparam logic [63:0] RECIP_W = (64'd1 << SHIFT) / 64'(BUCKETS);
      localparam logic [32:0] RECIP   = RECIP_W[32:0];
      localparam logic [31:0] DIVISOR = 32'(BUCKETS);

      logic [64:0] qprod_ff;
      logic [31:0] h2_ff;
      logic [31:0] h3_ff;
      logic [31:0] qb_ff;
      logic        v2_ff;
      logic        v3_ff;
      logic [31:0] quot;
      logic [63:0] qbprod;
      logic [31:0] rem;
      logic [31:0] rem_fix;

      // quotient estimate is exact or one short
      assign quot    = 32'(qprod_ff >> SHIFT);
      assign qbprod  = 64'(quot) * 64'(DIVISOR);
      assign rem     = h3_ff - qb_ff;
      assign rem_fix = (rem >= DIVISOR) ? rem - DIVISOR : rem;

      always_ff @(posedge clock) begin
         if (reset) begin
            v2_ff <= 1'b0;
            v3_ff <= 1'b0;
         end else begin
            v2_ff <= v1_ff;
            v3_ff <= v2_ff;
         end
      end

      always_ff @(posedge clock) begin
         qprod_ff <= 65'(hash_ff) * 65'(RECIP);
         h2_ff    <= hash_ff;
         qb_ff    <= qbprod[31:0];
         h3_ff    <= h2_ff;
      end

      assign done  = v3_ff;
      assign index = IDX_W'(rem_fix);
   end

endmodule

`default_nettype wire

// File: src/ttldmc_store.sv
// line memory, one write and one registered read port
`default_nettype none

module ttldmc_store import ttldmc_pkg::*; #(
   parameter int BUCKETS = BUCKETS_DEFAULT,
   localparam int IDX_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  line_type         wr_data,
   input  logic             rd_en,
   input  logic [IDX_W-1:0] rd_addr,
   output line_type         rd_data
);

   line_type mem [BUCKETS];
   line_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: src/ttl_direct_mapped_usage_cache.sv
// a request is hashed, its line is read and evaluated, and the result is then registered; the hash
//   is deeper when BUCKETS is not a power of two; a new request is taken only once the last result is
//   registered, as the hash, the line read and the read-modify-write of that line serve one request at a time
// clear all: result registered as for any other request, then a line sweep clears every line before the next request
// reset: counters zero, enable 1, ttl 100; a sweep clears all lines
//   before the first request is taken, register writes are taken throughout
`default_nettype none
`include "ttl_direct_mapped_usage_cache_macros.svh"

module ttl_direct_mapped_usage_cache import ttldmc_pkg::*; #(
   parameter int BUCKETS = BUCKETS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   ttldmc_req_if.sink   req_if,
   ttldmc_rsp_if.source rsp_if,
   ttldmc_csr_if.sink   csr_if
);

   localparam int IDX_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BUCKETS - 1);

   typedef enum logic [2:0] {S_SWEEP, S_IDLE, S_HASH, S_READ, S_RESP} state_type;

   state_type          state_ff;
   req_type            item_ff;
   logic               enable_ff;
   logic [TTL_W-1:0]   ttl_ff;
   logic [COUNT_W-1:0] hit_total_ff;
   logic [COUNT_W-1:0] miss_total_ff;
   logic [IDX_W-1:0]   sweep_ff;
   logic [IDX_W-1:0]   line_idx_ff;
   line_type           line_ff;
   logic               match_ff;
   logic               fresh_ff;
   logic [COUNT_W-1:0] cached_eff_ff;
   rsp_type            rsp_ff;
   logic               rsp_valid_ff;

   logic [TTL_W-1:0]   ttl_in;
   logic [COUNT_W-1:0] hit_total_in;
   logic [COUNT_W-1:0] miss_total_in;
   rsp_type            rsp_in;

   logic               req_accept;
   logic               out_free;
   logic               hash_done;
   logic [IDX_W-1:0]   hash_idx;
   logic               mem_rd_en;
   line_type           line_rd;
   logic               mem_wr_en;
   logic [IDX_W-1:0]   mem_wr_addr;
   line_type           mem_wr_data;

   logic               is_check;
   logic               hit_sel;
   logic               stale;
   logic [COUNT_W-1:0] eff;
   logic [COUNT_W:0]   sum;
   logic [TIME_W-1:0]  age;
   logic [COUNT_W-1:0] read_eff;
   req_type            req_item;

   assign req_if.ready = (state_ff == S_IDLE);
   assign csr_if.ready = 1'b1;
   assign req_accept   = req_if.valid && req_if.ready;
   assign out_free     = !rsp_valid_ff || rsp_if.ready;
   assign mem_rd_en    = (state_ff == S_HASH) && hash_done;

   assign req_item = '{
      opcode:           opcode_type'(req_if.opcode),
      proc_id:          req_if.proc_id,
      now_ms:           req_if.now_ms,
      resource_kind:    kind_type'(req_if.resource_kind),
      supplied_count:   req_if.supplied_count,
      requested:        req_if.requested,
      usage_limit:      req_if.usage_limit,
      new_qp_count:     req_if.new_qp_count,
      new_mr_count:     req_if.new_mr_count,
      new_memory_bytes: req_if.new_memory_bytes
   };

   ttldmc_hash #(.BUCKETS(BUCKETS)) u_hash (
      .clock   (clock),
      .reset   (reset),
      .start   (req_accept),
      .proc_id (req_if.proc_id),
      .done    (hash_done),
      .index   (hash_idx)
   );

   ttldmc_store #(.BUCKETS(BUCKETS)) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (hash_idx),
      .rd_data (line_rd)
   );

   // ttl write clamp
   always_comb begin
      ttl_in = csr_if.data[TTL_W-1:0];
      if (ttl_in < TTL_MIN) begin
         ttl_in = TTL_MIN;
      end else if (ttl_in > TTL_MAX) begin
         ttl_in = TTL_MAX;
      end
   end

   // line read evaluation
   assign age = item_ff.now_ms - line_rd.stamp;

   always_comb begin
      unique case (item_ff.resource_kind)
         KIND_QP:       read_eff = line_rd.qp;
         KIND_MR:       read_eff = line_rd.mr;
         KIND_MB:       read_eff = line_rd.mem[MB_SHIFT +: COUNT_W];
         KIND_SUPPLIED: read_eff = item_ff.supplied_count;
      endcase
   end

   // response and write-back
   assign is_check = (item_ff.opcode == OP_CHECK);
   assign hit_sel  = is_check && enable_ff && line_ff.valid && match_ff && fresh_ff;
   assign stale    = is_check && enable_ff && line_ff.valid && match_ff && !fresh_ff;
   assign eff      = hit_sel ? cached_eff_ff : item_ff.supplied_count;
   assign sum      = {1'b0, eff} + {1'b0, item_ff.requested};

   always_comb begin
      hit_total_in  = hit_total_ff;
      miss_total_in = miss_total_ff;
      unique case (item_ff.opcode)
         OP_CHECK: begin
            if (enable_ff) begin
               if (hit_sel) begin
                  hit_total_in = (hit_total_ff == '1) ? hit_total_ff : hit_total_ff + 32'd1;
               end else begin
                  miss_total_in = (miss_total_ff == '1) ? miss_total_ff
                                                        : miss_total_ff + 32'd1;
               end
            end
         end
         OP_CLEAR: begin
            hit_total_in  = '0;
            miss_total_in = '0;
         end
         OP_UPDATE, OP_INVALIDATE: begin
         end
      endcase

      rsp_in                     = '0;
      rsp_in.hit                 = hit_sel;
      rsp_in.allowed             = is_check && (sum <= {1'b0, item_ff.usage_limit});
      rsp_in.effective_count     = is_check ? eff : '0;
      rsp_in.cached_qp_count     = hit_sel ? line_ff.qp : '0;
      rsp_in.cached_mr_count     = hit_sel ? line_ff.mr : '0;
      rsp_in.cached_memory_bytes = hit_sel ? line_ff.mem : '0;
      rsp_in.hits_so_far         = hit_total_in;
      rsp_in.misses_so_far       = miss_total_in;
   end

   always_comb begin
      mem_wr_en         = 1'b0;
      mem_wr_addr       = line_idx_ff;
      mem_wr_data       = line_ff;
      mem_wr_data.valid = 1'b0;
      if (state_ff == S_SWEEP) begin
         mem_wr_en   = 1'b1;
         mem_wr_addr = sweep_ff;
         mem_wr_data = '0;
      end else if (state_ff == S_RESP && out_free) begin
         unique case (item_ff.opcode)
            OP_CHECK:      mem_wr_en = stale;
            OP_INVALIDATE: mem_wr_en = match_ff;
            OP_UPDATE: begin
               mem_wr_en   = enable_ff;
               mem_wr_data = '{
                  valid: 1'b1,
                  key:   item_ff.proc_id,
                  qp:    item_ff.new_qp_count,
                  mr:    item_ff.new_mr_count,
                  mem:   item_ff.new_memory_bytes,
                  stamp: item_ff.now_ms
               };
            end
            OP_CLEAR: mem_wr_en = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_SWEEP;
         sweep_ff      <= '0;
         item_ff       <= '0;
         enable_ff     <= 1'b1;
         ttl_ff        <= TTL_RESET;
         hit_total_ff  <= '0;
         miss_total_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_if.valid && csr_if.ready) begin
            priority case (csr_if.index)
               CSR_ENABLE: enable_ff <= csr_if.data[0];
               CSR_TTL:    ttl_ff    <= ttl_in;
               default: begin
               end
            endcase
         end

         if (state_ff == S_RESP && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.valid && rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_SWEEP: begin
               sweep_ff <= sweep_ff + 1'b1;
               if (sweep_ff == LAST_IDX) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_accept) begin
                  item_ff  <= req_item;
                  state_ff <= S_HASH;
               end
            end
            S_HASH: begin
               if (hash_done) begin
                  line_idx_ff <= hash_idx;
                  state_ff    <= S_READ;
               end
            end
            S_READ: begin
               line_ff       <= line_rd;
               match_ff      <= (line_rd.key == item_ff.proc_id);
               fresh_ff      <= (age <= TIME_W'(ttl_ff));
               cached_eff_ff <= read_eff;
               state_ff      <= S_RESP;
            end
            S_RESP: begin
               if (out_free) begin
                  rsp_ff        <= rsp_in;
                  hit_total_ff  <= hit_total_in;
                  miss_total_ff <= miss_total_in;
                  if (item_ff.opcode == OP_CLEAR) begin
                     sweep_ff <= '0;
                     state_ff <= S_SWEEP;
                  end else begin
                     state_ff <= S_IDLE;
                  end
               end
            end
         endcase
      end
   end

   assign rsp_if.valid               = rsp_valid_ff;
   assign rsp_if.hit                 = rsp_ff.hit;
   assign rsp_if.allowed             = rsp_ff.allowed;
   assign rsp_if.effective_count     = rsp_ff.effective_count;
   assign rsp_if.cached_qp_count     = rsp_ff.cached_qp_count;
   assign rsp_if.cached_mr_count     = rsp_ff.cached_mr_count;
   assign rsp_if.cached_memory_bytes = rsp_ff.cached_memory_bytes;
   assign rsp_if.hits_so_far         = rsp_ff.hits_so_far;
   assign rsp_if.misses_so_far       = rsp_ff.misses_so_far;

   `TTLDMC_ASSERT_NOW(a_wr_phase, clock, reset, mem_wr_en, state_ff == S_RESP || state_ff == S_SWEEP)
   `TTLDMC_ASSERT_NOW(a_no_rw_overlap, clock, reset, mem_rd_en, !mem_wr_en)
   `TTLDMC_ASSERT_NEXT(a_cnt_hold, clock, reset, state_ff != S_RESP, $stable(hit_total_ff) && $stable(miss_total_ff))
   `TTLDMC_ASSERT_NEXT(a_hit_count, clock, reset, state_ff == S_RESP && out_free && hit_sel && hit_total_ff != '1, hit_total_ff == $past(hit_total_ff) + 32'd1)

endmodule

`default_nettype wire

// File: tb/sv/tb_ttl_direct_mapped_usage_cache.sv
// self-checking testbench for the ttl direct-mapped usage cache
`timescale 1ns / 100ps

module tb_ttl_direct_mapped_usage_cache import ttldmc_pkg::*; ;

   localparam int unsigned LINES       = BUCKETS_DEFAULT;
   localparam int          STALL_LIMIT = 2000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ttldmc_req_if req_bus ();
   ttldmc_rsp_if rsp_bus ();
   ttldmc_csr_if csr_bus ();

   ttl_direct_mapped_usage_cache dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // usage cache predictor state
   bit                 slot_live  [LINES];
   logic [ID_W-1:0]    slot_owner [LINES];
   logic [COUNT_W-1:0] slot_qp    [LINES];
   logic [COUNT_W-1:0] slot_mr    [LINES];
   logic [BYTES_W-1:0] slot_bytes [LINES];
   logic [TIME_W-1:0]  slot_stamp [LINES];
   logic [COUNT_W-1:0] hit_tally  = '0;
   logic [COUNT_W-1:0] miss_tally = '0;
   logic               cfg_enable = 1'b1;
   logic [TTL_W-1:0]   cfg_ttl    = TTL_RESET;

   req_type req_backlog [$];
   rsp_type expected_rsp [$];

   // stimulus side view of which lines ever got a key
   bit                gen_touched [LINES];
   logic [TIME_W-1:0] gen_now;
   logic [ID_W-1:0]   pool_id [16];

   bit req_taken   = 1'b0;
   bit steady_flow = 1'b0;
   int error_count = 0;
   int stall_cycles = 0;

   function automatic int unsigned line_index(input logic [ID_W-1:0] id);
      logic [31:0] h;
      h = 32'(id) * HASH_MULT;
      return h % LINES;
   endfunction

   function automatic logic [COUNT_W-1:0] bump(input logic [COUNT_W-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   function automatic rsp_type cache_predict(input req_type rq);
      rsp_type           res;
      int unsigned       at;
      logic [TIME_W-1:0] age;
      res = '0;
      at = line_index(rq.proc_id);
      case (rq.opcode)
         OP_CHECK: begin
            res.effective_count = rq.supplied_count;
            if (cfg_enable) begin
               age = rq.now_ms - slot_stamp[at];
               if (!slot_live[at] || slot_owner[at] != rq.proc_id) begin
                  miss_tally = bump(miss_tally);
               end else if (age > cfg_ttl) begin
                  slot_live[at] = 1'b0;
                  miss_tally = bump(miss_tally);
               end else begin
                  res.hit = 1'b1;
                  res.cached_qp_count = slot_qp[at];
                  res.cached_mr_count = slot_mr[at];
                  res.cached_memory_bytes = slot_bytes[at];
                  hit_tally = bump(hit_tally);
                  case (rq.resource_kind)
                     KIND_QP: res.effective_count = slot_qp[at];
                     KIND_MR: res.effective_count = slot_mr[at];
                     KIND_MB: res.effective_count = 32'(slot_bytes[at] >> MB_SHIFT);
                     default: ;
                  endcase
               end
            end
            res.allowed = ({1'b0, res.effective_count} + {1'b0, rq.requested})
                          <= {1'b0, rq.usage_limit};
         end
         OP_UPDATE: begin
            if (cfg_enable) begin
               slot_owner[at] = rq.proc_id;
               slot_qp[at]    = rq.new_qp_count;
               slot_mr[at]    = rq.new_mr_count;
               slot_bytes[at] = rq.new_memory_bytes;
               slot_stamp[at] = rq.now_ms;
               slot_live[at]  = 1'b1;
            end
         end
         OP_INVALIDATE: begin
            if (slot_owner[at] == rq.proc_id) slot_live[at] = 1'b0;
         end
         default: begin
            foreach (slot_live[k]) slot_live[k] = 1'b0;
            hit_tally = '0;
            miss_tally = '0;
         end
      endcase
      res.hits_so_far = hit_tally;
      res.misses_so_far = miss_tally;
      return res;
   endfunction

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         error_count++;
      end
   endtask

   task automatic queue_item(input opcode_type op, input logic [ID_W-1:0] id,
                             input logic [TIME_W-1:0] now, input kind_type kind,
                             input logic [COUNT_W-1:0] supplied, input logic [COUNT_W-1:0] asked,
                             input logic [COUNT_W-1:0] limit, input logic [COUNT_W-1:0] qp,
                             input logic [COUNT_W-1:0] mr, input logic [BYTES_W-1:0] mem);
      req_type item;
      item.opcode = op;
      item.proc_id = id;
      item.now_ms = now;
      item.resource_kind = kind;
      item.supplied_count = supplied;
      item.requested = asked;
      item.usage_limit = limit;
      item.new_qp_count = qp;
      item.new_mr_count = mr;
      item.new_memory_bytes = mem;
      if (op == OP_UPDATE && cfg_enable) gen_touched[line_index(id)] = 1'b1;
      req_backlog.push_back(item);
   endtask

   function automatic logic [COUNT_W-1:0] pick_count();
      int unsigned sel;
      sel = $urandom_range(99);
      if (sel < 50) return $urandom;
      if (sel < 80) return $urandom_range(0, 1000);
      return 32'hFFFF_FFFF - $urandom_range(0, 1000);
   endfunction

   task automatic queue_random_item();
      int unsigned        sel;
      opcode_type         op;
      logic [ID_W-1:0]    id;
      logic [BYTES_W-1:0] mem;
      sel = $urandom_range(99);
      if (sel < 75) gen_now += 48'($urandom_range(0, cfg_ttl / 3));
      else if (sel < 90) gen_now += 48'(cfg_ttl + $urandom_range(0, 1));
      else if (sel < 95) gen_now -= 48'($urandom_range(1, 50));
      else gen_now = 48'({$urandom, $urandom});
      if ($urandom_range(99) < 88) id = pool_id[$urandom_range(0, 15)];
      else id = 22'($urandom);
      sel = $urandom_range(99);
      if (sel < 52) op = OP_CHECK;
      else if (sel < 82) op = OP_UPDATE;
      else if (sel < 97) op = OP_INVALIDATE;
      else op = OP_CLEAR;
      // never compare against a key that was never written
      if (op == OP_INVALIDATE && !gen_touched[line_index(id)]) op = OP_CHECK;
      if ($urandom_range(1)) mem = {$urandom, $urandom};
      else mem = (64'($urandom_range(0, 5000)) << MB_SHIFT) | 64'($urandom_range(0, 1023));
      queue_item(op, id, gen_now, kind_type'($urandom_range(0, 3)), pick_count(),
                 pick_count(), pick_count(), pick_count(), pick_count(), mem);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      if (idx == CSR_ENABLE) cfg_enable = value[0];
      else if (idx == CSR_TTL)
         cfg_ttl = (value < TTL_MIN) ? TTL_MIN : (value > TTL_MAX) ? TTL_MAX : value;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic wait_drain();
      do @(posedge clock);
      while (req_backlog.size() != 0 || req_bus.valid || expected_rsp.size() != 0);
   endtask

   // request driver and response backpressure
   always @(negedge clock) begin : req_driver
      req_type pending;
      if (!reset && (!req_bus.valid || req_taken)) begin
         req_taken = 1'b0;
         if (req_backlog.size() != 0 && (steady_flow || $urandom_range(99) >= 34)) begin
            pending = req_backlog.pop_front();
            req_bus.valid            <= 1'b1;
            req_bus.opcode           <= pending.opcode;
            req_bus.proc_id          <= pending.proc_id;
            req_bus.now_ms           <= pending.now_ms;
            req_bus.resource_kind    <= pending.resource_kind;
            req_bus.supplied_count   <= pending.supplied_count;
            req_bus.requested        <= pending.requested;
            req_bus.usage_limit      <= pending.usage_limit;
            req_bus.new_qp_count     <= pending.new_qp_count;
            req_bus.new_mr_count     <= pending.new_mr_count;
            req_bus.new_memory_bytes <= pending.new_memory_bytes;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
      rsp_bus.ready <= steady_flow || ($urandom_range(99) >= 34);
   end

   // request capture, response check and stall watchdog
   always @(posedge clock) begin : observer
      req_type taken;
      rsp_type want;
      bit      progress;
      progress = 1'b0;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            taken.opcode           = opcode_type'(req_bus.opcode);
            taken.proc_id          = req_bus.proc_id;
            taken.now_ms           = req_bus.now_ms;
            taken.resource_kind    = kind_type'(req_bus.resource_kind);
            taken.supplied_count   = req_bus.supplied_count;
            taken.requested        = req_bus.requested;
            taken.usage_limit      = req_bus.usage_limit;
            taken.new_qp_count     = req_bus.new_qp_count;
            taken.new_mr_count     = req_bus.new_mr_count;
            taken.new_memory_bytes = req_bus.new_memory_bytes;
            expected_rsp.push_back(cache_predict(taken));
            req_taken = 1'b1;
            progress = 1'b1;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            progress = 1'b1;
            if (expected_rsp.size() == 0) begin
               $error("response with no request outstanding");
               error_count++;
            end else begin
               want = expected_rsp.pop_front();
               check_field("hit", want.hit, rsp_bus.hit);
               check_field("allowed", want.allowed, rsp_bus.allowed);
               check_field("effective_count", want.effective_count, rsp_bus.effective_count);
               check_field("cached_qp_count", want.cached_qp_count, rsp_bus.cached_qp_count);
               check_field("cached_mr_count", want.cached_mr_count, rsp_bus.cached_mr_count);
               check_field("cached_memory_bytes", want.cached_memory_bytes,
                           rsp_bus.cached_memory_bytes);
               check_field("hits_so_far", want.hits_so_far, rsp_bus.hits_so_far);
               check_field("misses_so_far", want.misses_so_far, rsp_bus.misses_so_far);
            end
         end
         if (csr_bus.valid && csr_bus.ready) progress = 1'b1;
         stall_cycles = progress ? 0 : stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   initial begin
      logic [ID_W-1:0]       id_a;
      logic [ID_W-1:0]       id_b;
      logic [ID_W-1:0]       id_top;
      logic [7:0]            low_byte;
      bit                    phase_on  [6];
      logic [CSR_DATA_W-1:0] phase_ttl [6];

      req_bus.valid = 1'b0;
      req_bus.opcode = OP_CHECK;
      req_bus.proc_id = '0;
      req_bus.now_ms = '0;
      req_bus.resource_kind = KIND_QP;
      req_bus.supplied_count = '0;
      req_bus.requested = '0;
      req_bus.usage_limit = '0;
      req_bus.new_qp_count = '0;
      req_bus.new_mr_count = '0;
      req_bus.new_memory_bytes = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = CSR_ENABLE;
      csr_bus.data = '0;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: ttl edges, every kind, key collision, wrap, invalidate, clear
      id_a = 22'h012345;
      id_b = 22'h02AB45;
      id_top = 22'h3FFFFF;
      queue_item(OP_CHECK, id_a, 48'd1000, KIND_QP, 9, 1, 10, 0, 0, 0);
      queue_item(OP_UPDATE, id_a, 48'd1000, KIND_QP, 0, 0, 0, 32'hFFFF_FFFF, 0, '1);
      queue_item(OP_CHECK, id_a, 48'd1100, KIND_QP, 0, 0, 32'hFFFF_FFFF, 0, 0, 0);
      queue_item(OP_CHECK, id_a, 48'd1050, KIND_MR, 5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0);
      queue_item(OP_CHECK, id_a, 48'd1050, KIND_MB, 0, 1, 32'hFFFF_FFFF, 0, 0, 0);
      queue_item(OP_CHECK, id_a, 48'd1050, KIND_SUPPLIED, 7, 3, 10, 0, 0, 0);
      queue_item(OP_CHECK, id_b, 48'd1050, KIND_QP, 4, 4, 8, 0, 0, 0);
      queue_item(OP_CHECK, id_a, 48'd1101, KIND_QP, 1, 1, 1, 0, 0, 0);
      queue_item(OP_CHECK, id_a, 48'd1002, KIND_QP, 1, 1, 2, 0, 0, 0);
      queue_item(OP_UPDATE, id_a, 48'd2000, KIND_QP, 0, 0, 0, 3, 4, 64'h0A40_0000);
      queue_item(OP_INVALIDATE, id_b, 48'd2000, KIND_QP, 0, 0, 0, 0, 0, 0);
      queue_item(OP_CHECK, id_a, 48'd2010, KIND_MB, 0, 36, 200, 0, 0, 0);
      queue_item(OP_INVALIDATE, id_a, 48'd2010, KIND_QP, 0, 0, 0, 0, 0, 0);
      queue_item(OP_CHECK, id_a, 48'd2020, KIND_QP, 0, 0, 0, 0, 0, 0);
      queue_item(OP_UPDATE, id_top, 48'hFFFF_FFFF_FFF0, KIND_QP, 0, 0, 0, 1, 2, 3);
      queue_item(OP_CHECK, id_top, 48'h10, KIND_MR, 0, 5, 7, 0, 0, 0);
      queue_item(OP_CLEAR, id_top, 48'h10, KIND_QP, 0, 0, 0, 0, 0, 0);
      queue_item(OP_CHECK, id_top, 48'h10, KIND_MR, 0, 0, 0, 0, 0, 0);
      queue_item(OP_UPDATE, '0, '0, KIND_QP, 0, 0, 0, 0, 32'hFFFF_FFFF, 0);
      queue_item(OP_CHECK, '0, '0, KIND_MR, 0, 0, 0, 0, 0, 0);
      queue_item(OP_INVALIDATE, id_top, 48'h20, KIND_QP, 0, 0, 0, 0, 0, 0);

      // random ids in pairs that share a line
      for (int i = 0; i < 16; i += 2) begin
         low_byte = 8'($urandom);
         pool_id[i]     = {14'($urandom), low_byte};
         pool_id[i + 1] = {14'($urandom), low_byte};
      end
      gen_now = 48'd5000;
      phase_on  = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
      phase_ttl = '{14'h3FFF, 14'd0, 14'd100, 14'd10000, 14'd10, 14'd10};
      phase_ttl[4] = 14'($urandom_range(10, 10000));

      for (int p = 0; p < 6; p++) begin
         wait_drain();
         write_reg(CSR_ENABLE, {13'b0, phase_on[p]});
         write_reg(CSR_TTL, phase_ttl[p]);
         steady_flow = (p == 3);
         if (p == 4) gen_now = 48'hFFFF_FFFF_FF00;
         repeat (phase_on[p] ? 65 : 30) queue_random_item();
      end

      wait_drain();
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+src
src/ttldmc_pkg.sv
src/ttldmc_if.sv
src/ttldmc_hash.sv
src/ttldmc_store.sv
src/ttl_direct_mapped_usage_cache.sv
tb/sv/tb_ttl_direct_mapped_usage_cache.sv
